// ===== design/crcbe_pkg.sv =====
// shared types and constants of the configurable crc byte engine
// used by the top level, the front end and the back end; depends on nothing else

package crcbe_pkg;

  localparam int BYTE_BITS      = 8;
  localparam int WIDTH_BITS     = 6;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_DATA_BITS-1:0] RESET_POLYNOMIAL = 32'h0000_8005;
  localparam logic [WIDTH_BITS-1:0]    RESET_WIDTH      = 6'd16;
  localparam logic [WIDTH_BITS-1:0]    MIN_WIDTH        = 6'd8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_POLYNOMIAL = 1'b0,
    REG_CRC_WIDTH  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last_byte;
  } item_t;

endpackage

// ===== design/configurable_crc_byte_engine.sv =====
// top level of the configurable crc byte engine
// depends on crcbe_pkg, crcbe_fifo, crcbe_front and crcbe_back
//
// usage:
//   message bytes enter through a queue-style port: an item is taken at a
//   clock edge with in_push high and in_full low. in_last_byte marks the end
//   of a message; only that item yields a result, the finished crc, masked to
//   the configured width, on out_crc_value while out_empty is low. out_pop
//   with out_empty low takes it.
//   the crc is msb-first, non-reflected, initial value zero, no final xor.
//   cfg_we writes cfg_data into register cfg_index (polynomial, crc width);
//   write only while no message bytes are in flight.
// timing:
//   one item per cycle sustained while the result queue has room; each byte
//   goes through an item queue and then one eight-step update in the back
//   end before its result is registered in the result queue. QUEUE_DEPTH sets both queues.
// reset and stalls:
//   reset empties both queues, clears the running crc and restores the
//   polynomial 0x8005 and width 16. when out_pop stays low, results collect
//   in the result queue; once it is full the back end holds the next last
//   byte, the item queue fills and in_full rises.

module configurable_crc_byte_engine #(
  parameter int MAX_WIDTH   = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [crcbe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [crcbe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_push,
  input  logic [crcbe_pkg::BYTE_BITS-1:0]      in_data_byte,
  input  logic                                in_last_byte,
  output logic                                in_full,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [MAX_WIDTH-1:0]                out_crc_value
);

  localparam int ITEM_BITS = $bits(crcbe_pkg::item_t);

  crcbe_pkg::item_t                item_in, item_out;
  logic                            item_push, item_full, item_pop, item_empty;
  logic [ITEM_BITS-1:0]            item_rdata;
  logic [MAX_WIDTH-1:0]            poly, mask, top;
  logic [crcbe_pkg::WIDTH_BITS-1:0] byte_shift;
  logic                            res_push, res_full;
  logic [MAX_WIDTH-1:0]            res_crc;

  crcbe_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_full      (in_full),
    .item_push    (item_push),
    .item         (item_in),
    .item_full    (item_full),
    .poly         (poly),
    .mask         (mask),
    .top          (top),
    .byte_shift   (byte_shift)
  );

  crcbe_fifo #(
    .WIDTH (ITEM_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (item_push),
    .wdata (item_in),
    .full  (item_full),
    .pop   (item_pop),
    .rdata (item_rdata),
    .empty (item_empty)
  );

  assign item_out = crcbe_pkg::item_t'(item_rdata);

  crcbe_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_empty (item_empty),
    .item       (item_out),
    .item_pop   (item_pop),
    .poly       (poly),
    .mask       (mask),
    .top        (top),
    .byte_shift (byte_shift),
    .res_push   (res_push),
    .res_crc    (res_crc),
    .res_full   (res_full)
  );

  crcbe_fifo #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_crc),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_crc_value),
    .empty (out_empty)
  );

endmodule

// ===== design/crcbe_fifo.sv =====
// small first-in first-out queue with registered storage
// generic in width and depth; depends on nothing else

module crcbe_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== design/crcbe_front.sv =====
// front end: configuration registers, derived crc geometry, input item intake
// depends on crcbe_pkg

module crcbe_front #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [crcbe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [crcbe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_push,
  input  logic [crcbe_pkg::BYTE_BITS-1:0]      in_data_byte,
  input  logic                                in_last_byte,
  output logic                                in_full,
  output logic                                item_push,
  output crcbe_pkg::item_t                    item,
  input  logic                                item_full,
  output logic [MAX_WIDTH-1:0]                poly,
  output logic [MAX_WIDTH-1:0]                mask,
  output logic [MAX_WIDTH-1:0]                top,
  output logic [crcbe_pkg::WIDTH_BITS-1:0]     byte_shift
);

  localparam logic [crcbe_pkg::WIDTH_BITS-1:0] MAX_W =
    crcbe_pkg::WIDTH_BITS'(MAX_WIDTH);

  logic [MAX_WIDTH-1:0]             poly_r, poly_nxt;
  logic [crcbe_pkg::WIDTH_BITS-1:0] width_r, width_nxt;
  logic [crcbe_pkg::WIDTH_BITS-1:0] eff_width;

  always_comb begin
    poly_nxt  = poly_r;
    width_nxt = width_r;
    if (cfg_we) begin
      unique case (cfg_index)
        crcbe_pkg::REG_POLYNOMIAL: poly_nxt  = cfg_data[MAX_WIDTH-1:0];
        crcbe_pkg::REG_CRC_WIDTH:  width_nxt = cfg_data[crcbe_pkg::WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= crcbe_pkg::RESET_POLYNOMIAL[MAX_WIDTH-1:0];
      width_r <= crcbe_pkg::RESET_WIDTH;
    end else begin
      poly_r  <= poly_nxt;
      width_r <= width_nxt;
    end
  end

  // clamp the width into the supported range
  always_comb begin
    if (width_r < crcbe_pkg::MIN_WIDTH) begin
      eff_width = crcbe_pkg::MIN_WIDTH;
    end else if (width_r > MAX_W) begin
      eff_width = MAX_W;
    end else begin
      eff_width = width_r;
    end
  end

  // shift by the full word width yields zero, so the mask becomes all ones
  assign mask       = ~({MAX_WIDTH{1'b1}} << eff_width);
  assign top        = {{(MAX_WIDTH-1){1'b0}}, 1'b1} << (eff_width - crcbe_pkg::WIDTH_BITS'(1));
  assign poly       = poly_r & mask;
  assign byte_shift = eff_width - crcbe_pkg::MIN_WIDTH;

  assign in_full         = item_full;
  assign item_push       = in_push;
  assign item.data_byte  = in_data_byte;
  assign item.last_byte  = in_last_byte;

endmodule

// ===== design/crcbe_back.sv =====
// back end: running crc register and the eight-step byte update
// depends on crcbe_pkg

module crcbe_back #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_empty,
  input  crcbe_pkg::item_t                item,
  output logic                            item_pop,
  input  logic [MAX_WIDTH-1:0]            poly,
  input  logic [MAX_WIDTH-1:0]            mask,
  input  logic [MAX_WIDTH-1:0]            top,
  input  logic [crcbe_pkg::WIDTH_BITS-1:0] byte_shift,
  output logic                            res_push,
  output logic [MAX_WIDTH-1:0]            res_crc,
  input  logic                            res_full
);

  logic [MAX_WIDTH-1:0] crc_r, crc_nxt;
  logic [MAX_WIDTH-1:0] crc_upd;

  always_comb begin
    logic [MAX_WIDTH-1:0] c;
    logic                 msb;
    c = (crc_r & mask) ^ (MAX_WIDTH'(item.data_byte) << byte_shift);
    for (int i = 0; i < crcbe_pkg::BYTE_BITS; i++) begin
      msb = |(c & top);
      c   = ((c << 1) ^ (msb ? poly : '0)) & mask;
    end
    crc_upd = c;
  end

  // a last item waits until the result queue has room
  assign item_pop = !item_empty && (!item.last_byte || !res_full);
  assign res_push = item_pop && item.last_byte;
  assign res_crc  = crc_upd;

  always_comb begin
    crc_nxt = crc_r;
    if (item_pop) begin
      crc_nxt = item.last_byte ? '0 : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule
